@@ rtl/lsdg_pkg.sv @@
// ----------------------------------------------------------------------------
// lsdg_pkg
// Shared widths, register indexes, switch positions and types for the
// limit switch debounce guard.
// ----------------------------------------------------------------------------
`default_nettype none

package lsdg_pkg;

  localparam int unsigned NUM_SWITCHES = 4;
  localparam int unsigned CNT_W        = 8;
  localparam int unsigned PERIOD_W     = 16;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned IN_DATA_W    = 8;
  localparam int unsigned OUT_DATA_W   = 16;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HB_EN     = 2'd2;

  // reset values of the configuration registers
  localparam logic [CNT_W-1:0]    THRESHOLD_RST = 8'd6;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd100;

  // bit positions of the switches in switch_levels
  localparam int unsigned SW_V_UP    = 0;
  localparam int unsigned SW_V_DOWN  = 1;
  localparam int unsigned SW_H_RIGHT = 2;
  localparam int unsigned SW_H_LEFT  = 3;

  // per-switch status after one tick
  typedef struct packed {
    logic active;
    logic hit;
  } chan_status_t;

endpackage

`default_nettype wire

@@ rtl/lsdg_debounce_chan.sv @@
// ----------------------------------------------------------------------------
// lsdg_debounce_chan
// One switch: saturating count of consecutive pressed ticks and the latched
// trigger flag. Reports the flag and hit event of the tick being stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module lsdg_debounce_chan (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic                      pressed,
  input  wire logic [lsdg_pkg::CNT_W-1:0] threshold,
  output lsdg_pkg::chan_status_t         status
);

  logic [lsdg_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                       flag_r, flag_nxt;
  logic                       hit;

  assign cnt_inc = cnt_r + lsdg_pkg::CNT_W'(1);

  always_comb begin
    cnt_nxt  = cnt_r;
    flag_nxt = flag_r;
    hit      = 1'b0;
    if (pressed) begin
      // counter only increments while below the threshold, so the increment cannot wrap
      if (cnt_r < threshold) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc == threshold) begin
          hit      = 1'b1;
          flag_nxt = 1'b1;
        end
      end
    end else begin
      cnt_nxt  = '0;
      flag_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      flag_r <= 1'b0;
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      flag_r <= flag_nxt;
    end
  end

  assign status.active = flag_nxt;
  assign status.hit    = hit;

endmodule

`default_nettype wire

@@ rtl/limit_switch_debounce_guard.sv @@
// ----------------------------------------------------------------------------
// limit_switch_debounce_guard
// Debounces four active-low limit switches, raises stop and status signals
// and gives per-direction movement permission.
// ----------------------------------------------------------------------------
// path: an accepted item passes the input reg, then the result reg
// throughput: one item per cycle while the result register is not stalled; all counters update in a single pass
// a stalled result register holds its item while one more waits in the input reg
// reset: synchronous active low; counters, flags, heartbeat and valids clear,
// registers return to threshold 6, period 100, heartbeat off
`default_nettype none

module limit_switch_debounce_guard (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_we,
  input  wire logic [lsdg_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [lsdg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input items
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // [3:0] switch_levels, [4] h_moving_left, [5] v_moving_down, [7:6] zero
  input  wire logic [lsdg_pkg::IN_DATA_W-1:0]   in_tdata,
  // result items
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // [3:0] limit_active, [7:4] limit_hit_event, [8] stop_calibration,
  // [9] stop_horizontal, [10] stop_vertical, [11] status_report,
  // [12] move_left_allowed, [13] move_right_allowed,
  // [14] move_up_allowed, [15] move_down_allowed
  output logic [lsdg_pkg::OUT_DATA_W-1:0]       out_tdata
);

  localparam int unsigned NSW = lsdg_pkg::NUM_SWITCHES;

  // configuration registers
  logic [lsdg_pkg::CNT_W-1:0]    threshold_r;
  logic [lsdg_pkg::PERIOD_W-1:0] period_r;
  logic                          hb_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= lsdg_pkg::THRESHOLD_RST;
      period_r    <= lsdg_pkg::PERIOD_RST;
      hb_en_r     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        lsdg_pkg::CFG_THRESHOLD: threshold_r <= cfg_wdata[lsdg_pkg::CNT_W-1:0];
        lsdg_pkg::CFG_PERIOD:    period_r    <= cfg_wdata[lsdg_pkg::PERIOD_W-1:0];
        lsdg_pkg::CFG_HB_EN:     hb_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  logic                 in_valid_r;
  logic [NSW-1:0]       levels_r;
  logic                 left_r, down_r;
  logic                 advance;

  assign advance   = in_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      levels_r <= in_tdata[NSW-1:0];
      left_r   <= in_tdata[NSW];
      down_r   <= in_tdata[NSW+1];
    end
  end

  // per-switch debounce
  lsdg_pkg::chan_status_t chan_st [NSW];
  logic [NSW-1:0]         active, hits;

  for (genvar g = 0; g < NSW; g++) begin : g_chan
    lsdg_debounce_chan u_chan (
      .clk       (clk),
      .rst_n     (rst_n),
      .step      (advance),
      .pressed   (!levels_r[g]),
      .threshold (threshold_r),
      .status    (chan_st[g])
    );
    assign active[g] = chan_st[g].active;
    assign hits[g]   = chan_st[g].hit;
  end

  // heartbeat
  logic [lsdg_pkg::PERIOD_W-1:0] hb_ticks_r, hb_ticks_nxt, hb_inc;
  logic                          hb_elapsed;

  assign hb_inc = hb_ticks_r + lsdg_pkg::PERIOD_W'(1);

  always_comb begin
    hb_ticks_nxt = hb_ticks_r;
    hb_elapsed   = 1'b0;
    if (hb_en_r) begin
      if (hb_inc >= period_r) begin
        hb_ticks_nxt = '0;
        hb_elapsed   = 1'b1;
      end else begin
        hb_ticks_nxt = hb_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hb_ticks_r <= '0;
    end else if (advance) begin
      hb_ticks_r <= hb_ticks_nxt;
    end
  end

  // result assembly
  logic stop_h, stop_v, report;

  assign stop_h = (hits[lsdg_pkg::SW_H_LEFT] && left_r)
               || (hits[lsdg_pkg::SW_H_RIGHT] && !left_r);
  assign stop_v = (hits[lsdg_pkg::SW_V_DOWN] && down_r)
               || (hits[lsdg_pkg::SW_V_UP] && !down_r);
  assign report = hb_elapsed && (|active);

  logic [lsdg_pkg::OUT_DATA_W-1:0] result;

  assign result = {!active[lsdg_pkg::SW_V_DOWN],
                   !active[lsdg_pkg::SW_V_UP],
                   !active[lsdg_pkg::SW_H_RIGHT],
                   !active[lsdg_pkg::SW_H_LEFT],
                   report, stop_v, stop_h, |hits,
                   hits, active};

  // result register
  logic                            out_valid_r;
  logic [lsdg_pkg::OUT_DATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  // a hit always comes with its flag latched in the same result
  a_hit_latched: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[7:4] & ~out_tdata[3:0]) == 4'b0000))
    else $error("hit event without latched flag");

  // an axis stop needs the calibration stop, that is a hit on some switch
  a_stop_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[9] || out_tdata[10]) |-> out_tdata[8])
    else $error("axis stop without calibration stop");

  // status report only with heartbeat on and a limit active
  a_report_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> hb_en_r && (out_tdata[3:0] != 4'b0000))
    else $error("status report without cause");

  // the input side only stalls while an item waits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_tvalid && !out_tready)
    else $error("input stalled without a pending item");
`endif

endmodule

`default_nettype wire

@@ test/limit_switch_debounce_guard_tb.sv @@
// ----------------------------------------------------------------------------
// limit_switch_debounce_guard_tb
// Self-checking bench for the limit switch debounce guard. A tracker class
// mirrors the debounce counters, latched flags and heartbeat for every
// accepted tick and checks each status item field by field. Directed ticks
// cover the extremes first, then random press and release runs follow under
// several register settings and several idling patterns on both streams.
// ----------------------------------------------------------------------------

module limit_switch_debounce_guard_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 400000;
  localparam logic [lsdg_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

  // one input item: [3:0] switch levels, [4] moving left, [5] moving down
  typedef struct packed {
    logic [1:0] spare;
    logic       down;
    logic       left;
    logic [3:0] levels;
  } tick_in_t;

  // one result item, lowest field last
  typedef struct packed {
    logic       down_ok;
    logic       up_ok;
    logic       right_ok;
    logic       left_ok;
    logic       report;
    logic       stop_v;
    logic       stop_h;
    logic       stop_cal;
    logic [3:0] hits;
    logic [3:0] active;
  } guard_status_t;

  class debounce_tracker;
    logic [lsdg_pkg::CNT_W-1:0]    thresh;
    logic [lsdg_pkg::PERIOD_W-1:0] period;
    logic                          hb_on;
    logic [lsdg_pkg::CNT_W-1:0]    press_cnt [lsdg_pkg::NUM_SWITCHES];
    logic                          latched [lsdg_pkg::NUM_SWITCHES];
    logic [lsdg_pkg::PERIOD_W-1:0] hb_ticks;
    guard_status_t                 status_due [$];
    int                            mismatches;
    int                            ticks_taken;
    int                            statuses_seen;
    int                            hit_events;
    int                            reports;

    function new();
      thresh   = lsdg_pkg::THRESHOLD_RST;
      period   = lsdg_pkg::PERIOD_RST;
      hb_on    = 1'b0;
      hb_ticks = '0;
      foreach (press_cnt[i]) begin
        press_cnt[i] = '0;
        latched[i]   = 1'b0;
      end
    endfunction

    function void write_reg(logic [lsdg_pkg::CFG_ADDR_W-1:0] idx,
                            logic [lsdg_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        lsdg_pkg::CFG_THRESHOLD: thresh = val[lsdg_pkg::CNT_W-1:0];
        lsdg_pkg::CFG_PERIOD:    period = val[lsdg_pkg::PERIOD_W-1:0];
        lsdg_pkg::CFG_HB_EN:     hb_on  = val[0];
        default: ;
      endcase
    endfunction

    function void take_tick(logic [lsdg_pkg::IN_DATA_W-1:0] raw);
      tick_in_t      t;
      guard_status_t s;
      logic [3:0]    act;
      logic [3:0]    hits;
      logic          rep;
      t    = raw;
      act  = '0;
      hits = '0;
      rep  = 1'b0;
      for (int i = 0; i < lsdg_pkg::NUM_SWITCHES; i++) begin
        if (!t.levels[i]) begin
          if (press_cnt[i] < thresh) begin
            press_cnt[i] = press_cnt[i] + 1'b1;
            if (press_cnt[i] == thresh) begin
              latched[i] = 1'b1;
              hits[i]    = 1'b1;
            end
          end
        end else begin
          press_cnt[i] = '0;
          latched[i]   = 1'b0;
        end
        act[i] = latched[i];
      end
      // heartbeat wraps in 16 bits, elapsed period restarts from zero
      if (hb_on) begin
        hb_ticks = hb_ticks + 1'b1;
        if (hb_ticks >= period) begin
          hb_ticks = '0;
          rep      = |act;
        end
      end
      s.active   = act;
      s.hits     = hits;
      s.stop_cal = |hits;
      s.stop_h   = (hits[lsdg_pkg::SW_H_LEFT] & t.left)
                 | (hits[lsdg_pkg::SW_H_RIGHT] & ~t.left);
      s.stop_v   = (hits[lsdg_pkg::SW_V_DOWN] & t.down)
                 | (hits[lsdg_pkg::SW_V_UP] & ~t.down);
      s.report   = rep;
      s.left_ok  = ~act[lsdg_pkg::SW_H_LEFT];
      s.right_ok = ~act[lsdg_pkg::SW_H_RIGHT];
      s.up_ok    = ~act[lsdg_pkg::SW_V_UP];
      s.down_ok  = ~act[lsdg_pkg::SW_V_DOWN];
      status_due.push_back(s);
      ticks_taken++;
      hit_events += $countones(hits);
      reports    += rep;
    endfunction

    function void compare(string name, logic [3:0] exp_v, logic [3:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on status %0d, %s: expected %h, got %h",
                   statuses_seen, name, exp_v, act_v);
      end
    endfunction

    function void check_status(logic [lsdg_pkg::OUT_DATA_W-1:0] raw);
      guard_status_t got;
      guard_status_t want;
      got = raw;
      statuses_seen++;
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status item %h arrived with nothing outstanding", raw);
        return;
      end
      want = status_due.pop_front();
      compare("limit_active", want.active, got.active);
      compare("limit_hit_event", want.hits, got.hits);
      compare("stop_calibration", want.stop_cal, got.stop_cal);
      compare("stop_horizontal", want.stop_h, got.stop_h);
      compare("stop_vertical", want.stop_v, got.stop_v);
      compare("status_report", want.report, got.report);
      compare("move_left_allowed", want.left_ok, got.left_ok);
      compare("move_right_allowed", want.right_ok, got.right_ok);
      compare("move_up_allowed", want.up_ok, got.up_ok);
      compare("move_down_allowed", want.down_ok, got.down_ok);
    endfunction

    function int outstanding();
      return status_due.size();
    endfunction
  endclass

  logic                            clk       = 1'b0;
  logic                            rst_n     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [lsdg_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [lsdg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [lsdg_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lsdg_pkg::OUT_DATA_W-1:0] out_tdata;

  debounce_tracker tracker = new();
  int unsigned     cycle_count = 0;
  int              send_gap_pct = 0;
  int              stall_pct = 0;
  int              settings_used = 1;

  limit_switch_debounce_guard DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // both handshakes are sampled with their pre-edge values
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.take_tick(in_tdata);
      if (out_tvalid && out_tready)
        tracker.check_status(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("timeout with %0d status items outstanding", tracker.outstanding());
      $display("limit_switch_debounce_guard regression: fail");
      $finish;
    end
  end

  task automatic send_tick(input logic [3:0] levels, input logic left, input logic down);
    tick_in_t t;
    t.spare  = '0;
    t.down   = down;
    t.left   = left;
    t.levels = levels;
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop sending and let every outstanding status item come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lsdg_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [lsdg_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // upper data bits are junk on purpose, the spare index must be ignored
  task automatic program_regs(input logic [7:0] thr, input logic [15:0] per, input logic en);
    write_reg(lsdg_pkg::CFG_THRESHOLD, {8'($urandom), thr});
    write_reg(lsdg_pkg::CFG_PERIOD, per);
    write_reg(lsdg_pkg::CFG_HB_EN, {15'($urandom), en});
    write_reg(CFG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      1:       begin send_gap_pct = 47; stall_pct = 0;  end
      2:       begin send_gap_pct = 0;  stall_pct = 47; end
      3:       begin send_gap_pct = 7;  stall_pct = 7;  end
      default: begin send_gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  // each switch goes through random press and release runs, long presses reach the threshold
  task automatic run_random(input int n, input int bounce_pct);
    bit         pressed [lsdg_pkg::NUM_SWITCHES];
    int         hold [lsdg_pkg::NUM_SWITCHES];
    logic [3:0] lv;
    int         thr;
    thr = int'(tracker.thresh);
    foreach (hold[i]) begin
      hold[i]    = 0;
      pressed[i] = 1'b0;
    end
    repeat (n) begin
      for (int i = 0; i < lsdg_pkg::NUM_SWITCHES; i++) begin
        if (hold[i] == 0) begin
          pressed[i] = ($urandom_range(99) < 55);
          hold[i] = pressed[i] ? $urandom_range(1, 2 * thr + 3) : $urandom_range(1, 8);
        end
        hold[i]--;
        lv[i] = ~pressed[i];
      end
      if ($urandom_range(99) < bounce_pct)
        lv = 4'($urandom_range(15));
      send_tick(lv, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: threshold 6, heartbeat off
    set_idle(0);
    send_tick(4'hF, 1'b0, 1'b0);
    repeat (6) send_tick(4'h0, 1'b1, 1'b1);
    repeat (2) send_tick(4'h0, 1'b0, 1'b0);
    send_tick(4'hF, 1'b1, 1'b0);
    drain();

    // single-tick threshold, heartbeat elapsing on every tick
    program_regs(8'd1, 16'd0, 1'b1);
    send_tick(4'h0, 1'b0, 1'b0);
    send_tick(4'h0, 1'b1, 1'b1);
    send_tick(4'hF, 1'b0, 1'b0);
    send_tick(4'h5, 1'b0, 1'b0);
    send_tick(4'hA, 1'b1, 1'b1);
    drain();

    // threshold zero never triggers
    program_regs(8'd0, 16'd65535, 1'b0);
    repeat (3) send_tick(4'h0, 1'b1, 1'b0);
    send_tick(4'hF, 1'b0, 1'b1);
    drain();

    // counts run up, then the threshold drops below them
    program_regs(8'd200, 16'd3, 1'b1);
    repeat (10) send_tick(4'h0, 1'($urandom_range(1)), 1'($urandom_range(1)));
    drain();
    program_regs(8'd5, 16'd3, 1'b1);
    repeat (3) send_tick(4'h0, 1'b0, 1'b1);
    send_tick(4'h7, 1'b1, 1'b0);
    drain();

    set_idle(0);
    program_regs(8'd3, 16'd5, 1'b1);
    run_random(200, 5);
    drain();

    set_idle(1);
    program_regs(8'd1, 16'd1, 1'b1);
    run_random(200, 10);
    drain();

    set_idle(2);
    program_regs(8'd8, 16'd0, 1'b1);
    run_random(200, 5);
    drain();

    set_idle(3);
    program_regs(8'd255, 16'd65535, 1'b1);
    run_random(470, 0);
    drain();

    set_idle(1);
    program_regs(8'd4, 16'd7, 1'b0);
    run_random(200, 5);
    drain();

    set_idle(2);
    program_regs(8'd2, 16'd3, 1'b1);
    run_random(200, 40);
    drain();

    set_idle(3);
    program_regs(8'($urandom_range(1, 12)), 16'($urandom_range(1, 20)), 1'b1);
    run_random(200, 10);
    drain();

    $display("run covered %0d ticks and %0d status items under %0d register settings",
             tracker.ticks_taken, tracker.statuses_seen, settings_used);
    $display("%0d hit events and %0d status reports seen, %0d field mismatches",
             tracker.hit_events, tracker.reports, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("limit_switch_debounce_guard regression: pass");
    end else begin
      $display("limit_switch_debounce_guard regression: fail");
    end
    $finish;
  end

endmodule

@@ limit_switch_debounce_guard.f @@
rtl/lsdg_pkg.sv
rtl/lsdg_debounce_chan.sv
rtl/limit_switch_debounce_guard.sv
test/limit_switch_debounce_guard_tb.sv
